// ----- design/nwls_pkg.sv -----
// ----------------------------------------------------------------------------
// nwls_pkg
// Shared types and constants of the nearest waypoint local search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nwls_pkg;

  localparam int IDX_W        = 11;
  localparam int FIELD_IDX_W  = 10;
  localparam int SPAN_W       = 4;
  localparam int OUT_DATA_W   = ((FIELD_IDX_W + 7) / 8) * 8;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 4'd4;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    ST_OK        = 1'b0,
    ST_BAD_START = 1'b1
  } status_e;

  typedef enum logic {
    REG_PATH_LENGTH  = 1'b0,
    REG_RECHECK_SPAN = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_FWD,
    PH_REC
  } phase_e;

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [IDX_W-1:0] idx;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- design/nwls_store.sv -----
// ----------------------------------------------------------------------------
// nwls_store
// Waypoint memory: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nwls_store
  import nwls_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 1024,
  parameter int COORD_WIDTH   = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mem_req_t                   req_i,
  input  logic [3*COORD_WIDTH-1:0]   wdata_i,
  output logic [3*COORD_WIDTH-1:0]   rdata_o,
  output logic                       rvalid_o
);

  localparam int AW = $clog2(MAX_WAYPOINTS);

  logic [3*COORD_WIDTH-1:0] mem [MAX_WAYPOINTS];
  logic [AW+IDX_W-1:0]      idx_ext;
  logic [AW-1:0]            addr;
  logic [3*COORD_WIDTH-1:0] rdata_q;
  logic                     rvalid_q;

  assign idx_ext = {{AW{1'b0}}, req_i.idx};
  assign addr    = idx_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[addr] <= wdata_i;
    end
    if (req_i.rd) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= req_i.rd;
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

`default_nettype wire

// ----- design/nwls_dist.sv -----
// ----------------------------------------------------------------------------
// nwls_dist
// Squared distance pipeline: difference, square, sum; three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module nwls_dist
  import nwls_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            qload_i,
  input  logic signed [COORD_WIDTH-1:0]   qx_i,
  input  logic signed [COORD_WIDTH-1:0]   qy_i,
  input  logic signed [COORD_WIDTH-1:0]   qz_i,
  input  logic                            rvalid_i,
  input  logic [3*COORD_WIDTH-1:0]        rdata_i,
  output logic [2*COORD_WIDTH+1:0]        dist_o,
  output logic                            dist_valid_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int SQ_W = 2 * CW;
  localparam int D_W  = 2 * CW + 2;

  logic signed [CW-1:0] q_q   [3];
  logic signed [CW:0]   diff  [3];
  logic        [CW:0]   mag   [3];
  logic        [CW-1:0] mag_q [3];
  logic        [SQ_W-1:0] sq_q [3];
  logic        [D_W-1:0]  sum_q;
  logic                   v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (qload_i) begin
      q_q[0] <= qx_i;
      q_q[1] <= qy_i;
      q_q[2] <= qz_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({rdata_i[i*CW+CW-1], rdata_i[i*CW +: CW]})
              - $signed({q_q[i][CW-1], q_q[i]});
      mag[i]  = diff[i][CW] ? (~diff[i] + 1'b1) : diff[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag_q[i] <= mag[i][CW-1:0];
      sq_q[i]  <= SQ_W'(mag_q[i]) * SQ_W'(mag_q[i]);
    end
    sum_q <= D_W'(sq_q[0]) + D_W'(sq_q[1]) + D_W'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= rvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign dist_o       = sum_q;
  assign dist_valid_o = v3_q;

endmodule

`default_nettype wire

// ----- design/nwls_ctrl.sv -----
// ----------------------------------------------------------------------------
// nwls_ctrl
// Search sequencer: forward walk, descending recheck, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nwls_ctrl
  import nwls_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 1024,
  parameter int COORD_WIDTH   = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [FIELD_IDX_W-1:0]       entry_index_i,
  input  logic [FIELD_IDX_W-1:0]       start_index_i,
  input  logic [IDX_W-1:0]             path_length_i,
  input  logic [SPAN_W-1:0]            recheck_span_i,
  output mem_req_t                     mem_req_o,
  output logic                         qload_o,
  input  logic [2*COORD_WIDTH+1:0]     dist_i,
  input  logic                         dist_valid_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [FIELD_IDX_W-1:0]       out_index_o,
  output logic                         out_status_o
);

  localparam int D_W = 2 * COORD_WIDTH + 2;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [IDX_W-1:0]   cand_q, best_q, base_q;
  logic [D_W-1:0]     bd_q;
  logic               err_q;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_IDX_W-1:0] out_index_q;
  logic               out_status_q;

  logic [IDX_W-1:0]   len_eff;
  logic [IDX_W-1:0]   start_ext, entry_ext;
  logic               accept, is_query, bad_start, entry_ok;
  logic               step, better, fwd_go, rec_start, rec_cont, go;
  logic [IDX_W-1:0]   best_n, cand_n, cand_dec;
  logic [D_W-1:0]     bd_n;
  logic [IDX_W:0]     nxt_fwd, top;
  logic               out_load;

  assign len_eff   = (int'(path_length_i) > MAX_WAYPOINTS) ? IDX_W'(MAX_WAYPOINTS)
                                                           : path_length_i;
  assign start_ext = {1'b0, start_index_i};
  assign entry_ext = {1'b0, entry_index_i};
  assign entry_ok  = int'(entry_index_i) < MAX_WAYPOINTS;
  assign is_query  = (op_e'(op_i) == OP_QUERY);
  assign bad_start = start_ext >= len_eff;
  assign accept    = in_valid_i && in_ready_o;
  assign step      = (state_q == S_WAIT) && dist_valid_i;
  assign out_load  = !out_valid_q || out_ready_i;

  // search decisions for the entry whose distance is ready
  always_comb begin
    better    = (phase_q == PH_FIRST) || (dist_i <= bd_q);
    best_n    = better ? cand_q : best_q;
    bd_n      = better ? dist_i : bd_q;
    nxt_fwd   = {1'b0, cand_q} + 1'b1;
    top       = {1'b0, best_n} + (IDX_W+1)'(recheck_span_i);
    cand_dec  = cand_q - 1'b1;
    fwd_go    = (phase_q != PH_REC) && better && (nxt_fwd < {1'b0, len_eff});
    rec_start = (phase_q != PH_REC) && !fwd_go && (recheck_span_i != '0)
                && (top < {1'b0, len_eff});
    rec_cont  = (phase_q == PH_REC) && ({1'b0, cand_q} > ({1'b0, base_q} + 1'b1));
    go        = fwd_go || rec_start || rec_cont;
    priority if (fwd_go) begin
      cand_n = nxt_fwd[IDX_W-1:0];
    end else if (rec_start) begin
      cand_n = top[IDX_W-1:0];
    end else begin
      cand_n = cand_dec;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && is_query) begin
          state_d = bad_start ? S_DONE : S_WAIT;
        end
      end
      S_WAIT: begin
        if (dist_valid_i && !go) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    qload_o       = accept && is_query;
    mem_req_o     = '0;
    if (accept && !is_query && entry_ok) begin
      mem_req_o.wr  = 1'b1;
      mem_req_o.idx = entry_ext;
    end else if (accept && is_query && !bad_start) begin
      mem_req_o.rd  = 1'b1;
      mem_req_o.idx = start_ext;
    end else if (step && go) begin
      mem_req_o.rd  = 1'b1;
      mem_req_o.idx = cand_n;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (accept && is_query) begin
      phase_d = PH_FIRST;
    end else if (step && fwd_go) begin
      phase_d = PH_FWD;
    end else if (step && rec_start) begin
      phase_d = PH_REC;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == S_DONE) && out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_query) begin
      cand_q <= start_ext;
      best_q <= '0;
      err_q  <= bad_start;
    end else if (step) begin
      best_q <= best_n;
      bd_q   <= bd_n;
      if (go) begin
        cand_q <= cand_n;
      end
      if (rec_start) begin
        base_q <= best_n;
      end
    end
    if ((state_q == S_DONE) && out_load) begin
      out_index_q  <= best_q[FIELD_IDX_W-1:0];
      out_status_q <= err_q ? ST_BAD_START : ST_OK;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

// ----- design/nearest_waypoint_local_search.sv -----
// ----------------------------------------------------------------------------
// nearest_waypoint_local_search
// Stored 3-D path with a local closest-waypoint search per query.
// ----------------------------------------------------------------------------
// A write item stores one waypoint and returns nothing. A query reads every
// table entry it examines (start, the forward walk and the recheck) from
// the single-port waypoint memory and passes it through three stages of
// distance arithmetic, and the choice of the next entry waits for each
// result. A bad start index is answered without a memory read. One item is
// in work at a time; the result register lets the next item in while a
// result waits to be taken.
`default_nettype none

module nearest_waypoint_local_search
  import nwls_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 1024,
  parameter int COORD_WIDTH   = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index, start_index, pos_x, pos_y, pos_z
  input  logic [((2*FIELD_IDX_W + 3*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // op
  input  logic        s_axis_tuser,
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // closest_index
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic        m_axis_tuser
);

  localparam int CW    = COORD_WIDTH;
  localparam int X_LSB = 2 * FIELD_IDX_W;

  logic [IDX_W-1:0]         path_length_q, path_length_d;
  logic [SPAN_W-1:0]        span_q, span_d;
  logic                     cfg_wr;
  mem_req_t                 mem_req;
  logic                     qload;
  logic [3*CW-1:0]          wdata, rdata;
  logic                     rvalid;
  logic [2*CW+1:0]          sq_dist;
  logic                     dist_valid;
  logic [FIELD_IDX_W-1:0]   out_index;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    path_length_d = path_length_q;
    span_d        = span_q;
    if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_PATH_LENGTH:  path_length_d = pwdata[IDX_W-1:0];
        REG_RECHECK_SPAN: span_d        = pwdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_length_q <= '0;
      span_q        <= SPAN_RESET;
    end else begin
      path_length_q <= path_length_d;
      span_q        <= span_d;
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_PATH_LENGTH:  prdata = 32'(path_length_q);
      REG_RECHECK_SPAN: prdata = 32'(span_q);
      default:          prdata = '0;
    endcase
  end

  assign wdata = s_axis_tdata[X_LSB +: 3*CW];

  nwls_ctrl #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tuser),
    .entry_index_i  (s_axis_tdata[FIELD_IDX_W-1:0]),
    .start_index_i  (s_axis_tdata[FIELD_IDX_W +: FIELD_IDX_W]),
    .path_length_i  (path_length_q),
    .recheck_span_i (span_q),
    .mem_req_o      (mem_req),
    .qload_o        (qload),
    .dist_i         (sq_dist),
    .dist_valid_i   (dist_valid),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_index_o    (out_index),
    .out_status_o   (m_axis_tuser)
  );

  nwls_store #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .wdata_i  (wdata),
    .rdata_o  (rdata),
    .rvalid_o (rvalid)
  );

  nwls_dist #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qload_i      (qload),
    .qx_i         (s_axis_tdata[X_LSB +: CW]),
    .qy_i         (s_axis_tdata[X_LSB + CW +: CW]),
    .qz_i         (s_axis_tdata[X_LSB + 2*CW +: CW]),
    .rvalid_i     (rvalid),
    .rdata_i      (rdata),
    .dist_o       (sq_dist),
    .dist_valid_o (dist_valid)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_index);

endmodule

`default_nettype wire

// ----- design/nwls_checker.sv -----
// ----------------------------------------------------------------------------
// nwls_checker
// Port-level checks of the nearest waypoint local search block.
// ----------------------------------------------------------------------------
`default_nettype none

module nwls_checker
  import nwls_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // bad start reports index zero
  a_err_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_BAD_START) |-> m_axis_tdata == '0)
    else $error("error result with nonzero index");

  // a query transfer lowers the input ready in the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY) |=> !s_axis_tready)
    else $error("input ready right after query");

  // a result only appears after the search has held the input
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without a query in work");

endmodule

bind nearest_waypoint_local_search nwls_checker u_nwls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/tb_nearest_waypoint_local_search.sv -----
// ----------------------------------------------------------------------------
// tb_nearest_waypoint_local_search
// Self-checking bench for the stored-path closest waypoint search.
// ----------------------------------------------------------------------------
// Waypoint writes and closest-point queries are sent over the input stream.
// A local copy of the path table and the two registers predicts every query
// answer: forward walk on squared distance, then the descending recheck
// window. Answers are compared field by field in order. Directed cases cover
// bad starts, coordinate extremes, ties, the recheck window and a clamped
// path length; random phases load short paths (and the tail of a long one)
// and query them, with random gaps on both streams except near the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nearest_waypoint_local_search;
  import nwls_pkg::*;

  localparam int COORD_W       = 24;
  localparam int MAX_WP        = 1024;
  localparam int IN_W          = ((2 * FIELD_IDX_W + 3 * COORD_W + 7) / 8) * 8;
  localparam int ITEM_TARGET   = 1050;
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [FIELD_IDX_W-1:0] index_t;

  typedef struct {
    index_t  idx;
    status_e st;
  } answer_t;

  localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [2:0]            paddr         = '0;
  logic [31:0]           pwdata        = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  coord_t      wp_x [MAX_WP];
  coord_t      wp_y [MAX_WP];
  coord_t      wp_z [MAX_WP];
  bit          wp_written [MAX_WP];
  logic [10:0] cfg_path_len = '0;
  logic [3:0]  cfg_span     = SPAN_RESET;

  answer_t     pending_answers [$];
  answer_t     head;
  int unsigned items_sent   = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  bit          quiet        = 1'b0;

  always #2 clk_i = ~clk_i;

  nearest_waypoint_local_search #(
    .MAX_WAYPOINTS(MAX_WP),
    .COORD_WIDTH  (COORD_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // ---------------------------------------------------------------- predictor

  function automatic longint dist_sq(int unsigned k, coord_t qx, coord_t qy, coord_t qz);
    longint dx, dy, dz;
    dx = longint'(wp_x[k]) - longint'(qx);
    dy = longint'(wp_y[k]) - longint'(qy);
    dz = longint'(wp_z[k]) - longint'(qz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic int unsigned effective_len();
    return (cfg_path_len > MAX_WP) ? MAX_WP : int'(cfg_path_len);
  endfunction

  function automatic answer_t predict_closest(index_t start, coord_t qx, coord_t qy,
                                              coord_t qz);
    answer_t     a;
    int unsigned len, best, base, n, top, k;
    longint      bd, nd;
    bit          walking;
    len = effective_len();
    if (start >= len) begin
      a.idx = '0;
      a.st  = ST_BAD_START;
      return a;
    end
    best    = start;
    bd      = dist_sq(start, qx, qy, qz);
    n       = start + 1;
    walking = 1'b1;
    while (walking && n < len) begin
      nd = dist_sq(n, qx, qy, qz);
      if (nd > bd) begin
        walking = 1'b0;
      end else begin
        bd   = nd;
        best = n;
        n++;
      end
    end
    top = best + cfg_span;
    if (cfg_span != 0 && top < len) begin
      base = best;
      for (k = top; k > base; k--) begin
        nd = dist_sq(k, qx, qy, qz);
        if (nd <= bd) begin
          bd   = nd;
          best = k;
        end
      end
    end
    a.idx = best[FIELD_IDX_W-1:0];
    a.st  = ST_OK;
    return a;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic coord_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[COORD_W-1:0];
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(CMAX)) return CMAX;
    if (v < longint'(CMIN)) return CMIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic coord_t jitter(coord_t c, int unsigned amp);
    return clamp_coord(longint'(c) + longint'($urandom_range(0, 2 * amp)) - longint'(amp));
  endfunction

  // lowest index from which every entry up to the path end is loaded
  function automatic int unsigned first_safe(int unsigned len);
    int unsigned i;
    i = len;
    while (i > 0 && wp_written[i-1]) i--;
    return i;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_item(op_e op, index_t entry, index_t start, coord_t x, coord_t y,
                           coord_t z);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({z, y, x, start, entry});
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (op == OP_WRITE) begin
      wp_x[entry]       = x;
      wp_y[entry]       = y;
      wp_z[entry]       = z;
      wp_written[entry] = 1'b1;
    end else begin
      pending_answers.insert(pending_answers.size(), predict_closest(start, x, y, z));
    end
  endtask

  task automatic write_waypoint(int unsigned entry, coord_t x, coord_t y, coord_t z);
    send_item(OP_WRITE, entry[FIELD_IDX_W-1:0], index_t'($urandom), x, y, z);
  endtask

  task automatic run_query(int unsigned start, coord_t x, coord_t y, coord_t z);
    send_item(OP_QUERY, index_t'($urandom), start[FIELD_IDX_W-1:0], x, y, z);
  endtask

  // hold the stream until every answer is back and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (r == REG_PATH_LENGTH) cfg_path_len = value[10:0];
    else cfg_span = value[3:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (r == REG_PATH_LENGTH) begin
      if (prdata[10:0] !== cfg_path_len) report_mismatch("path_length readback",
                                                         prdata[10:0], cfg_path_len);
    end else begin
      if (prdata[3:0] !== cfg_span) report_mismatch("recheck_span readback",
                                                    prdata[3:0], cfg_span);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int unsigned len, int unsigned span);
    wait_idle();
    write_reg(REG_PATH_LENGTH, len);
    write_reg(REG_RECHECK_SPAN, span);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_bad_start();
    run_query(0, rand_coord(), rand_coord(), rand_coord());
    run_query(MAX_WP - 1, rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_coordinate_extremes();
    configure(4, 0);
    write_waypoint(0, CMIN, CMIN, CMIN);
    write_waypoint(1, 0, 0, 0);
    write_waypoint(2, CMAX, CMAX, CMAX);
    write_waypoint(3, CMAX, CMIN, CMAX);
    write_waypoint(MAX_WP - 1, CMIN, CMAX, CMIN);
    run_query(0, CMAX, CMAX, CMAX);
    run_query(0, CMIN, CMIN, CMIN);
    run_query(3, CMIN, CMAX, CMIN);
    run_query(4, 0, 0, 0);
  endtask

  task automatic test_forward_ties();
    configure(8, 1);
    write_waypoint(4, 0, 0, 0);
    write_waypoint(5, 0, 0, 0);
    write_waypoint(6, 0, 0, 0);
    write_waypoint(7, 100, 0, 0);
    run_query(4, 0, 0, 0);
    run_query(6, 50, 0, 0);
  endtask

  task automatic test_recheck_window();
    configure(8, 2);
    write_waypoint(0, 0, 0, 0);
    write_waypoint(1, 900, 0, 0);
    write_waypoint(2, 2000, 0, 0);
    write_waypoint(3, 1000, 0, 0);
    run_query(0, 1000, 0, 0);
    configure(8, 15);
    run_query(0, 1000, 0, 0);
    run_query(4, 0, 0, 0);
  endtask

  task automatic test_long_path();
    configure(2047, 3);
    write_waypoint(1020, 3000, 0, 0);
    write_waypoint(1021, 2000, 0, 0);
    write_waypoint(1022, 2500, 0, 0);
    run_query(1020, 2100, 0, 0);
    run_query(1023, 0, 0, 0);
    configure(1023, 15);
    run_query(1021, 2100, 0, 0);
    run_query(1023, 0, 0, 0);
  endtask

  task automatic build_path(int unsigned len);
    int unsigned lo, i, amp;
    longint      px, py, pz, sx, sy, sz;
    if (len == 0) return;
    lo = (len <= 48) ? 0 : len - $urandom_range(16, 40);
    if ($urandom_range(0, 3) == 0) begin
      for (i = lo; i < len; i++) write_waypoint(i, rand_coord(), rand_coord(), rand_coord());
    end else begin
      px  = longint'(rand_coord()) / 2;
      py  = longint'(rand_coord()) / 2;
      pz  = longint'(rand_coord()) / 2;
      sx  = longint'($urandom_range(0, 2048)) - 1024;
      sy  = longint'($urandom_range(0, 2048)) - 1024;
      sz  = longint'($urandom_range(0, 256)) - 128;
      amp = $urandom_range(0, 3000);
      for (i = lo; i < len; i++) begin
        write_waypoint(i, jitter(clamp_coord(px + sx * (i - lo)), amp),
                          jitter(clamp_coord(py + sy * (i - lo)), amp),
                          jitter(clamp_coord(pz + sz * (i - lo)), amp));
      end
    end
  endtask

  task automatic test_random_paths();
    int unsigned len, eff, span, n_q, i, safe, s, k, amp, pick;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET * 4 / 5) quiet <= 1'b1;
      pick = $urandom_range(0, 19);
      case (pick)
        0:       len = 0;
        1:       len = MAX_WP;
        2:       len = $urandom_range(MAX_WP + 1, 2047);
        3:       len = $urandom_range(49, MAX_WP - 1);
        default: len = $urandom_range(1, 48);
      endcase
      pick = $urandom_range(0, 5);
      span = (pick == 0) ? 0 : (pick == 1) ? 15 : $urandom_range(0, 15);
      configure(len, span);
      eff = effective_len();
      build_path(eff);
      amp = $urandom_range(0, 1) ? $urandom_range(0, 500) : $urandom_range(0, 100000);
      n_q = $urandom_range(8, 30);
      for (i = 0; i < n_q; i++) begin
        safe = first_safe(eff);
        pick = $urandom_range(0, 9);
        if (pick == 1 || (safe >= eff && eff == MAX_WP)) begin
          write_waypoint($urandom_range(0, MAX_WP - 1), rand_coord(), rand_coord(),
                         rand_coord());
        end else if ((pick == 0 && eff < MAX_WP) || safe >= eff) begin
          run_query($urandom_range(eff, MAX_WP - 1), rand_coord(), rand_coord(),
                    rand_coord());
        end else begin
          s = $urandom_range(safe, eff - 1);
          k = $urandom_range(safe, eff - 1);
          if ($urandom_range(0, 7) == 0) begin
            run_query(s, rand_coord(), rand_coord(), rand_coord());
          end else begin
            run_query(s, jitter(wp_x[k], amp), jitter(wp_y[k], amp), jitter(wp_z[k], amp));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result index", m_axis_tdata[FIELD_IDX_W-1:0], 0);
      end else begin
        head = pending_answers.pop_front();
        if (m_axis_tdata[FIELD_IDX_W-1:0] !== head.idx)
          report_mismatch("closest_index", m_axis_tdata[FIELD_IDX_W-1:0], head.idx);
        if (m_axis_tdata[OUT_DATA_W-1:FIELD_IDX_W] !== '0)
          report_mismatch("tdata padding", m_axis_tdata[OUT_DATA_W-1:FIELD_IDX_W], 0);
        if (m_axis_tuser !== head.st)
          report_mismatch("status", m_axis_tuser, head.st);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (rst_ni && !quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_start();
    test_coordinate_extremes();
    test_forward_ties();
    test_recheck_window();
    test_long_path();
    test_random_paths();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
